// ===== design/brac_pkg.sv =====
package brac_pkg;

    localparam int BITMAP_BLOCKS_DEF  = 4;
    localparam int BITS_PER_BLOCK_DEF = 1024;

    localparam int WORD_W   = 32;
    localparam int WORD_BITS = 32;
    localparam int BIT_W    = 5;
    localparam int REC_W    = 12;
    localparam int STATUS_W = 2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK             = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL           = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOCATED  = 2'd2;

    typedef struct packed {
        logic             kind;
        logic [REC_W-1:0] record_index;
    } req_t;

    typedef struct packed {
        logic [REC_W-1:0]    allocated_index;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    typedef struct packed {
        logic             full;
        logic [BIT_W-1:0] lowest;
        logic             bit_hit;
    } word_info_t;

endpackage

// ===== design/bitmap_record_allocator_core.sv =====
// First-fit record allocator over a bitmap of 32-bit words kept in one RAM.
// Request channel (req_valid / req_stall / req): kind selects allocate or
// free; record_index names the record to free. Response channel
// (rsp_valid / rsp_stall / rsp): exactly one response per request, with
// allocated_index and status (ok, full, not allocated).
// One request is handled at a time; req_stall is high while it is in work.
// Allocate: for each word scanned, a RAM read state (S_ARD), then a test
// state (S_ACHK), over up to SLOT_WORDS words, then S_RESP to respond; the
// single RAM read port and the word test unit set this. Free: S_FDIV steps
// one block at a time to locate the record (at most BITMAP_BLOCKS), then
// S_FRD reads, S_FCHK tests and S_RESP responds. The next request is taken
// in S_IDLE once the response register loads, never while one is in work.
// After reset a clearing pass writes every word (SLOT_WORDS words, 128 at
// default settings), leaving only record 0 set; requests stall meanwhile.
// The response sits in an output register; if rsp_stall holds it there, a
// finished request waits for the register to free up before responding.
module bitmap_record_allocator_core #(
    parameter int BITMAP_BLOCKS  = brac_pkg::BITMAP_BLOCKS_DEF,
    parameter int BITS_PER_BLOCK = brac_pkg::BITS_PER_BLOCK_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  brac_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output brac_pkg::rsp_t rsp
);

    localparam int WPB        = BITS_PER_BLOCK / brac_pkg::WORD_BITS;
    localparam int SLOT_WORDS = BITMAP_BLOCKS * WPB;
    localparam int TOTAL      = BITMAP_BLOCKS * BITS_PER_BLOCK;
    localparam int AW         = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
    localparam int CW         = $clog2(SLOT_WORDS + 1);
    localparam int RW0        = $clog2(TOTAL + 1);
    localparam int RW         = (RW0 > brac_pkg::REC_W) ? RW0 : brac_pkg::REC_W;
    localparam int KW         = $clog2(BITMAP_BLOCKS + 1);
    localparam int WBW        = (WPB > 1) ? $clog2(WPB) : 1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_ARD   = 8'b00000100,
        S_ACHK  = 8'b00001000,
        S_FDIV  = 8'b00010000,
        S_FRD   = 8'b00100000,
        S_FCHK  = 8'b01000000,
        S_RESP  = 8'b10000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [AW-1:0]                 idx_reg, idx_next;
    logic [KW-1:0]                 k_reg, k_next;
    logic [WBW-1:0]                wib_reg, wib_next;
    logic [RW-1:0]                 rec_base_reg, rec_base_next;
    logic [RW-1:0]                 blk_base_reg, blk_base_next;
    logic [RW-1:0]                 within_reg, within_next;
    logic [CW-1:0]                 wbase_reg, wbase_next;
    logic [brac_pkg::REC_W-1:0]    res_idx_reg, res_idx_next;
    logic [brac_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    brac_pkg::rsp_t                rsp_reg, rsp_next;

    logic                          wr_en;
    logic [brac_pkg::WORD_W-1:0]   wr_data;
    logic [brac_pkg::WORD_W-1:0]   rd_data;
    brac_pkg::word_info_t          info;
    logic [brac_pkg::WORD_W-1:0]   set_word;
    logic [brac_pkg::WORD_W-1:0]   clr_word;
    logic [RW-1:0]                 word_in_blk;
    logic [CW-1:0]                 idx_calc;
    logic [RW-1:0]                 rec_found;

    brac_ram #(
        .WIDTH (brac_pkg::WORD_W),
        .DEPTH (SLOT_WORDS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    brac_word u_word (
        .word     (rd_data),
        .bit_sel  (within_reg[brac_pkg::BIT_W-1:0]),
        .info     (info),
        .set_word (set_word),
        .clr_word (clr_word)
    );

    assign word_in_blk = within_reg >> brac_pkg::BIT_W;
    assign idx_calc    = wbase_reg + word_in_blk[CW-1:0];
    assign rec_found   = rec_base_reg + RW'(info.lowest);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        wib_next        = wib_reg;
        rec_base_next   = rec_base_reg;
        blk_base_next   = blk_base_reg;
        within_next     = within_reg;
        wbase_next      = wbase_reg;
        res_idx_next    = res_idx_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg & rsp_stall;
        rsp_next        = rsp_reg;
        wr_en           = 1'b0;
        wr_data         = '0;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_data = (idx_reg == '0) ? brac_pkg::WORD_W'(1) : '0;
                if (idx_reg == AW'(SLOT_WORDS - 1))
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    idx_next        = '0;
                    k_next          = '0;
                    wib_next        = '0;
                    rec_base_next   = '0;
                    blk_base_next   = '0;
                    wbase_next      = '0;
                    within_next     = RW'(req.record_index);
                    res_idx_next    = '0;
                    state_next      = (req.kind == brac_pkg::KIND_ALLOC) ? S_ARD : S_FDIV;
                end
            end
            S_ARD:
            begin
                state_next = S_ACHK;
            end
            S_ACHK:
            begin
                if (!info.full)
                begin
                    wr_en           = 1'b1;
                    wr_data         = set_word;
                    res_idx_next    = rec_found[brac_pkg::REC_W-1:0];
                    res_status_next = brac_pkg::STATUS_OK;
                    state_next      = S_RESP;
                end
                else if (wib_reg == WBW'(WPB - 1) && k_reg == KW'(BITMAP_BLOCKS - 1))
                begin
                    res_idx_next    = '0;
                    res_status_next = brac_pkg::STATUS_FULL;
                    state_next      = S_RESP;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    if (wib_reg == WBW'(WPB - 1))
                    begin
                        wib_next      = '0;
                        k_next        = k_reg + KW'(1);
                        blk_base_next = blk_base_reg + RW'(BITS_PER_BLOCK);
                        rec_base_next = blk_base_reg + RW'(BITS_PER_BLOCK);
                    end
                    else
                    begin
                        wib_next      = wib_reg + WBW'(1);
                        rec_base_next = rec_base_reg + RW'(brac_pkg::WORD_BITS);
                    end
                    state_next = S_ARD;
                end
            end
            S_FDIV:
            begin
                if (k_reg == KW'(BITMAP_BLOCKS))
                begin
                    res_status_next = brac_pkg::STATUS_NOT_ALLOCATED;
                    state_next      = S_RESP;
                end
                else if (within_reg >= RW'(BITS_PER_BLOCK))
                begin
                    within_next = within_reg - RW'(BITS_PER_BLOCK);
                    k_next      = k_reg + KW'(1);
                    wbase_next  = wbase_reg + CW'(WPB);
                end
                else if (word_in_blk >= RW'(WPB))
                begin
                    res_status_next = brac_pkg::STATUS_NOT_ALLOCATED;
                    state_next      = S_RESP;
                end
                else
                begin
                    idx_next   = idx_calc[AW-1:0];
                    state_next = S_FRD;
                end
            end
            S_FRD:
            begin
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (info.bit_hit)
                begin
                    wr_en           = 1'b1;
                    wr_data         = clr_word;
                    res_status_next = brac_pkg::STATUS_OK;
                end
                else
                begin
                    res_status_next = brac_pkg::STATUS_NOT_ALLOCATED;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next.allocated_index = res_idx_reg;
                    rsp_next.status          = res_status_reg;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            k_reg         <= '0;
            wib_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            wib_reg       <= wib_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_base_reg   <= rec_base_next;
        blk_base_reg   <= blk_base_next;
        within_reg     <= within_next;
        wbase_reg      <= wbase_next;
        res_idx_reg    <= res_idx_next;
        res_status_reg <= res_status_next;
        rsp_reg        <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    a_rsp_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("response raised outside the respond state");

    a_achk_next: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACHK |=> (state_reg == S_ARD || state_reg == S_RESP))
        else $error("allocate scan left its loop unexpectedly");

    a_clear_writes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> (wr_en && req_stall))
        else $error("clearing pass skipped a write or took a request");

    a_free_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FDIV |-> k_reg <= KW'(BITMAP_BLOCKS))
        else $error("free locate stepped past the last block");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_RESP) |-> !wr_en)
        else $error("bitmap written outside a check or clear step");
`endif

endmodule

// ===== design/brac_ram.sv =====
module brac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/brac_word.sv =====
module brac_word (
    input  logic [brac_pkg::WORD_W-1:0] word,
    input  logic [brac_pkg::BIT_W-1:0]  bit_sel,
    output brac_pkg::word_info_t        info,
    output logic [brac_pkg::WORD_W-1:0] set_word,
    output logic [brac_pkg::WORD_W-1:0] clr_word
);

    // binary search for the lowest zero bit, five halving steps
    function automatic logic [brac_pkg::BIT_W-1:0] lowest_zero(
        input logic [brac_pkg::WORD_W-1:0] w
    );
        logic [brac_pkg::WORD_W-1:0] x;
        logic [brac_pkg::BIT_W-1:0]  pos;
        x   = ~w;
        pos = '0;
        if (x[15:0] == 16'h0)
        begin
            pos[4] = 1'b1;
            x      = x >> 16;
        end
        if (x[7:0] == 8'h0)
        begin
            pos[3] = 1'b1;
            x      = x >> 8;
        end
        if (x[3:0] == 4'h0)
        begin
            pos[2] = 1'b1;
            x      = x >> 4;
        end
        if (x[1:0] == 2'h0)
        begin
            pos[1] = 1'b1;
            x      = x >> 2;
        end
        if (x[0] == 1'b0)
        begin
            pos[0] = 1'b1;
        end
        return pos;
    endfunction

    assign info.full    = (word == '1);
    assign info.lowest  = lowest_zero(word);
    assign info.bit_hit = word[bit_sel];

    assign set_word = word | (brac_pkg::WORD_W'(1) << info.lowest);
    assign clr_word = word & ~(brac_pkg::WORD_W'(1) << bit_sel);

endmodule
